FILE: hdl/greedy_hit_track_matcher_macros.svh
// Assertion macros for the greedy hit/track matcher checker.
// Arguments: label, clock, active-low reset, antecedent, consequent.
`ifndef GREEDY_HIT_TRACK_MATCHER_MACROS_SVH
`define GREEDY_HIT_TRACK_MATCHER_MACROS_SVH

// consequent checked in the same cycle
`define GHTM_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("ghtm port check failed");

// consequent checked in the next cycle
`define GHTM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("ghtm port check failed");

`endif

FILE: hdl/ghtm_pkg.sv
// ----------------------------------------------------------------------------
// ghtm_pkg
// Shared types and constants of the greedy hit/track matcher.
// ----------------------------------------------------------------------------
package ghtm_pkg;

    localparam int MAX_TRACKS_DEF = 32;
    localparam int MAX_HITS_DEF   = 32;
    localparam int RESULT_LIMIT   = 32;

    localparam int COORD_W   = 20;
    localparam int CUT_W     = 19;
    localparam int DIST_W    = 21;
    localparam int OUT_IDX_W = 5;
    localparam int OUT_CNT_W = 6;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_LOAD_TRACK = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_HIT   = 2'd1;
    localparam logic [OP_W-1:0] OP_END_EVENT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RES_U = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RES_V = 1'd1;

    localparam logic [CUT_W-1:0] CUT_RESET = 19'd2000;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
    } in_item_t;

    typedef struct packed {
        logic                 hit_valid;
        logic [OUT_IDX_W-1:0] hit_index;
        logic                 has_track;
        logic [OUT_IDX_W-1:0] track_index;
        logic [DIST_W-1:0]    match_distance;
        logic [OUT_CNT_W-1:0] match_count;
        logic                 overflow;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] u;
        logic signed [COORD_W-1:0] v;
    } coord_t;

    typedef struct packed {
        logic [CUT_W-1:0] cut_u;
        logic [CUT_W-1:0] cut_v;
    } cut_cfg_t;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [DIST_W-1:0] distance;
    } pair_res_t;

endpackage

FILE: hdl/ghtm_store.sv
// ----------------------------------------------------------------------------
// ghtm_store
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ghtm_store #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 40,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/ghtm_dist.sv
// ----------------------------------------------------------------------------
// ghtm_dist
// Two-stage pair evaluator: absolute residuals, then cut check and distance.
// ----------------------------------------------------------------------------
module ghtm_dist #(
    parameter int TAG_W = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ghtm_pkg::cut_cfg_t  cuts,
    input  logic                in_valid,
    input  logic [TAG_W-1:0]    in_tag,
    input  ghtm_pkg::coord_t    trk,
    input  ghtm_pkg::coord_t    hit,
    output ghtm_pkg::pair_res_t res,
    output logic [TAG_W-1:0]    res_tag,
    output logic                busy
);

    localparam int CW = ghtm_pkg::COORD_W;
    localparam int DW = ghtm_pkg::DIST_W;

    logic [CW:0]   diff_u;
    logic [CW:0]   diff_v;
    logic [CW-1:0] abs_u;
    logic [CW-1:0] abs_v;

    logic             s2_valid_reg;
    logic [TAG_W-1:0] s2_tag_reg;
    logic [CW-1:0]    du_reg;
    logic [CW-1:0]    dv_reg;

    logic          en_u;
    logic          en_v;
    logic          fail_u;
    logic          fail_v;
    logic [DW-1:0] dist_sum;

    ghtm_pkg::pair_res_t res_reg;
    logic [TAG_W-1:0]    res_tag_reg;

    // residuals of two 20-bit signed values always fit 20 bits unsigned
    assign diff_u = {trk.u[CW-1], trk.u} - {hit.u[CW-1], hit.u};
    assign diff_v = {trk.v[CW-1], trk.v} - {hit.v[CW-1], hit.v};
    assign abs_u  = diff_u[CW] ? CW'(-diff_u) : CW'(diff_u);
    assign abs_v  = diff_v[CW] ? CW'(-diff_v) : CW'(diff_v);

    // zero cut disables both the cut and its distance term
    assign en_u     = |cuts.cut_u;
    assign en_v     = |cuts.cut_v;
    assign fail_u   = en_u && (du_reg >= CW'(cuts.cut_u));
    assign fail_v   = en_v && (dv_reg >= CW'(cuts.cut_v));
    assign dist_sum = (en_u ? DW'(du_reg) : '0) + (en_v ? DW'(dv_reg) : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            res_reg.valid <= 1'b0;
        end else begin
            s2_valid_reg  <= in_valid;
            res_reg.valid <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_tag_reg       <= in_tag;
        du_reg           <= abs_u;
        dv_reg           <= abs_v;
        res_tag_reg      <= s2_tag_reg;
        res_reg.ok       <= !fail_u && !fail_v;
        res_reg.distance <= dist_sum;
    end

    assign res     = res_reg;
    assign res_tag = res_tag_reg;
    assign busy    = s2_valid_reg || res_reg.valid;

endmodule

FILE: hdl/greedy_hit_track_matcher.sv
// ----------------------------------------------------------------------------
// greedy_hit_track_matcher: greedy nearest-pair track/hit matcher
// Loads: 1 request per cycle, taken while idle. End of event: (M+1) rounds of
// scan, drain and resolve (one pair per cycle through the coordinate RAM read ports, M =
// pairs matched; no rounds when T or H is 0), then a read state and an emit state per result.
// Sync active-low reset; RAMs not cleared.
// ----------------------------------------------------------------------------
module greedy_hit_track_matcher #(
    parameter int MAX_TRACKS = ghtm_pkg::MAX_TRACKS_DEF,
    parameter int MAX_HITS   = ghtm_pkg::MAX_HITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ghtm_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ghtm_pkg::out_item_t               m_data,
    input  logic                              cfg_we,
    input  logic [ghtm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [ghtm_pkg::CUT_W-1:0]        cfg_wdata
);

    localparam int TIW      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int HIW      = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int TCW      = $clog2(MAX_TRACKS + 1);
    localparam int HCW      = $clog2(MAX_HITS + 1);
    localparam int MIN_TH   = (MAX_TRACKS < MAX_HITS) ? MAX_TRACKS : MAX_HITS;
    localparam int MCW      = $clog2(MIN_TH + 1);
    localparam int EMIT_MAX = (MAX_HITS < ghtm_pkg::RESULT_LIMIT) ? MAX_HITS
                                                                  : ghtm_pkg::RESULT_LIMIT;
    localparam int DW       = ghtm_pkg::DIST_W;
    localparam int CRD_W    = $bits(ghtm_pkg::coord_t);
    localparam int RES_W    = TIW + DW;
    localparam int TAG_W    = TIW + HIW;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_RESOLVE = 3'd3;
    localparam logic [2:0] ST_RD      = 3'd4;
    localparam logic [2:0] ST_EMIT    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [ghtm_pkg::CUT_W-1:0] cut_u_reg;
    logic [ghtm_pkg::CUT_W-1:0] cut_v_reg;
    ghtm_pkg::cut_cfg_t         cuts;

    logic [TCW-1:0]        track_count_reg;
    logic [HCW-1:0]        hit_count_reg;
    logic                  overflow_reg;
    logic [MAX_TRACKS-1:0] track_taken_reg;
    logic [MAX_HITS-1:0]   hit_taken_reg;

    logic [TIW-1:0]   scan_t_reg;
    logic [HIW-1:0]   scan_h_reg;
    logic             s1_valid_reg;
    logic [TAG_W-1:0] s1_tag_reg;

    logic           found_reg;
    logic [TIW-1:0] best_t_reg;
    logic [HIW-1:0] best_h_reg;
    logic [DW-1:0]  best_d_reg;
    logic [MCW-1:0] match_cnt_reg;

    logic [HIW-1:0]      emit_k_reg;
    logic                m_valid_reg;
    ghtm_pkg::out_item_t m_data_reg;

    logic s_acc;
    logic trk_wr;
    logic hit_wr;
    logic trk_full;
    logic hit_full;
    logic t_last;
    logic h_last;
    logic pair_last;
    logic issue_skip;
    logic dist_busy;
    logic better;
    logic out_load;
    logic emit_last;
    logic emit_has;
    logic [HCW-1:0] emit_n;

    logic [CRD_W-1:0] trk_rd;
    logic [CRD_W-1:0] hit_rd;
    logic [RES_W-1:0] res_wdata;
    logic [RES_W-1:0] res_rd;
    logic [TIW-1:0]   res_partner;
    logic [DW-1:0]    res_dist;

    ghtm_pkg::pair_res_t pair_res;
    logic [TAG_W-1:0]    pair_tag;
    ghtm_pkg::coord_t    load_crd;

    // ------------------------------------------------------------------
    // Handshake and load decode
    // ------------------------------------------------------------------
    assign s_ready  = aresetn && (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign trk_full = (track_count_reg == TCW'(MAX_TRACKS));
    assign hit_full = (hit_count_reg == HCW'(MAX_HITS));
    assign trk_wr   = s_acc && (s_data.operation == ghtm_pkg::OP_LOAD_TRACK) && !trk_full;
    assign hit_wr   = s_acc && (s_data.operation == ghtm_pkg::OP_LOAD_HIT) && !hit_full;

    assign load_crd.u = s_data.coord_u;
    assign load_crd.v = s_data.coord_v;

    assign cuts.cut_u = cut_u_reg;
    assign cuts.cut_v = cut_v_reg;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    ghtm_store #(
        .DEPTH (MAX_TRACKS),
        .WIDTH (CRD_W),
        .AW    (TIW)
    ) u_trk_store (
        .aclk    (aclk),
        .wr_en   (trk_wr),
        .wr_addr (track_count_reg[TIW-1:0]),
        .wr_data (load_crd),
        .rd_addr (scan_t_reg),
        .rd_data (trk_rd)
    );

    ghtm_store #(
        .DEPTH (MAX_HITS),
        .WIDTH (CRD_W),
        .AW    (HIW)
    ) u_hit_store (
        .aclk    (aclk),
        .wr_en   (hit_wr),
        .wr_addr (hit_count_reg[HIW-1:0]),
        .wr_data (load_crd),
        .rd_addr (scan_h_reg),
        .rd_data (hit_rd)
    );

    // per-hit partner and distance, written once per matched round
    assign res_wdata = {best_t_reg, best_d_reg};

    ghtm_store #(
        .DEPTH (MAX_HITS),
        .WIDTH (RES_W),
        .AW    (HIW)
    ) u_res_store (
        .aclk    (aclk),
        .wr_en   ((state_reg == ST_RESOLVE) && found_reg),
        .wr_addr (best_h_reg),
        .wr_data (res_wdata),
        .rd_addr (emit_k_reg),
        .rd_data (res_rd)
    );

    assign res_partner = res_rd[RES_W-1:DW];
    assign res_dist    = res_rd[DW-1:0];

    // ------------------------------------------------------------------
    // Pair scan: track-major, one pair issued per cycle
    // ------------------------------------------------------------------
    assign t_last     = ((TCW'(scan_t_reg) + TCW'(1)) == track_count_reg);
    assign h_last     = ((HCW'(scan_h_reg) + HCW'(1)) == hit_count_reg);
    assign pair_last  = t_last && h_last;
    assign issue_skip = track_taken_reg[scan_t_reg] || hit_taken_reg[scan_h_reg];

    ghtm_dist #(
        .TAG_W (TAG_W)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cuts     (cuts),
        .in_valid (s1_valid_reg),
        .in_tag   (s1_tag_reg),
        .trk      (trk_rd),
        .hit      (hit_rd),
        .res      (pair_res),
        .res_tag  (pair_tag),
        .busy     (dist_busy)
    );

    // strict less keeps the first pair in scan order on ties
    assign better = pair_res.valid && pair_res.ok &&
                    (!found_reg || (pair_res.distance < best_d_reg));

    // ------------------------------------------------------------------
    // Result emission
    // ------------------------------------------------------------------
    assign emit_n    = (hit_count_reg > HCW'(EMIT_MAX)) ? HCW'(EMIT_MAX) : hit_count_reg;
    assign emit_last = (hit_count_reg == '0) || ((HCW'(emit_k_reg) + HCW'(1)) == emit_n);
    assign emit_has  = (hit_count_reg != '0) && hit_taken_reg[emit_k_reg];
    assign out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_data.operation == ghtm_pkg::OP_END_EVENT)) begin
                    state_next = ((track_count_reg == '0) || (hit_count_reg == '0)) ? ST_RD
                                                                                    : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pair_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!s1_valid_reg && !dist_busy) begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                state_next = found_reg ? ST_SCAN : ST_RD;
            end
            ST_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = emit_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cut_u_reg       <= ghtm_pkg::CUT_RESET;
            cut_v_reg       <= ghtm_pkg::CUT_RESET;
            track_count_reg <= '0;
            hit_count_reg   <= '0;
            overflow_reg    <= 1'b0;
            track_taken_reg <= '0;
            hit_taken_reg   <= '0;
            scan_t_reg      <= '0;
            scan_h_reg      <= '0;
            s1_valid_reg    <= 1'b0;
            found_reg       <= 1'b0;
            match_cnt_reg   <= '0;
            emit_k_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_addr)
                    ghtm_pkg::CFG_MAX_RES_U: cut_u_reg <= cfg_wdata;
                    ghtm_pkg::CFG_MAX_RES_V: cut_v_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (s_acc) begin
                case (s_data.operation)
                    ghtm_pkg::OP_LOAD_TRACK: begin
                        if (trk_full) begin
                            overflow_reg <= 1'b1;
                        end else begin
                            track_count_reg <= track_count_reg + TCW'(1);
                        end
                    end
                    ghtm_pkg::OP_LOAD_HIT: begin
                        if (hit_full) begin
                            overflow_reg <= 1'b1;
                        end else begin
                            hit_count_reg <= hit_count_reg + HCW'(1);
                        end
                    end
                    ghtm_pkg::OP_END_EVENT: begin
                        scan_t_reg    <= '0;
                        scan_h_reg    <= '0;
                        found_reg     <= 1'b0;
                        match_cnt_reg <= '0;
                        emit_k_reg    <= '0;
                    end
                    default: ;
                endcase
            end

            s1_valid_reg <= (state_reg == ST_SCAN) && !issue_skip;
            if (state_reg == ST_SCAN) begin
                if (h_last) begin
                    scan_h_reg <= '0;
                    scan_t_reg <= scan_t_reg + TIW'(1);
                end else begin
                    scan_h_reg <= scan_h_reg + HIW'(1);
                end
            end

            if ((state_reg == ST_RESOLVE) && found_reg) begin
                track_taken_reg[best_t_reg] <= 1'b1;
                hit_taken_reg[best_h_reg]   <= 1'b1;
                match_cnt_reg               <= match_cnt_reg + MCW'(1);
                scan_t_reg                  <= '0;
                scan_h_reg                  <= '0;
                found_reg                   <= 1'b0;
            end

            if (better) begin
                found_reg <= 1'b1;
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (emit_last) begin
                    track_count_reg <= '0;
                    hit_count_reg   <= '0;
                    overflow_reg    <= 1'b0;
                    track_taken_reg <= '0;
                    hit_taken_reg   <= '0;
                    emit_k_reg      <= '0;
                end else begin
                    emit_k_reg <= emit_k_reg + HIW'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_tag_reg <= {scan_t_reg, scan_h_reg};
        if (better) begin
            best_d_reg               <= pair_res.distance;
            {best_t_reg, best_h_reg} <= pair_tag;
        end
        if (out_load) begin
            m_data_reg.hit_valid      <= (hit_count_reg != '0);
            m_data_reg.hit_index      <= ghtm_pkg::OUT_IDX_W'(emit_k_reg);
            m_data_reg.has_track      <= emit_has;
            m_data_reg.track_index    <= emit_has ? ghtm_pkg::OUT_IDX_W'(res_partner) : '0;
            m_data_reg.match_distance <= emit_has ? res_dist : '0;
            m_data_reg.match_count    <= ghtm_pkg::OUT_CNT_W'(match_cnt_reg);
            m_data_reg.overflow       <= overflow_reg;
            m_data_reg.last           <= emit_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: hdl/ghtm_checker.sv
// ----------------------------------------------------------------------------
// ghtm_checker
// Port-level checks of the greedy hit/track matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_hit_track_matcher_macros.svh"

module ghtm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input ghtm_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input ghtm_pkg::out_item_t m_data
);

    // stalled result holds
    `GHTM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // end-of-event request blocks further requests while results are built
    `GHTM_ASSERT_NEXT(a_eoe_busy, aclk, aresetn, s_valid && s_ready && (s_data.operation == ghtm_pkg::OP_END_EVENT), !s_ready)

    // an event without hits yields a single closing result
    `GHTM_ASSERT_NOW(a_empty_last, aclk, aresetn, m_valid && !m_data.hit_valid, m_data.last && !m_data.has_track)

    // unmatched hits carry no partner or distance
    `GHTM_ASSERT_NOW(a_unmatched_zero, aclk, aresetn, m_valid && !m_data.has_track, (m_data.track_index == '0) && (m_data.match_distance == '0))

    // a matched hit implies a nonzero match count
    `GHTM_ASSERT_NOW(a_match_count, aclk, aresetn, m_valid && m_data.has_track, m_data.match_count != '0)

endmodule

bind greedy_hit_track_matcher ghtm_checker u_ghtm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for greedy_hit_track_matcher
// Sends track loads, hit loads and end-of-event requests with random gaps on
// both channels. A scoreboard predicts the greedy pairing of each event and
// checks every result in order. The residual cuts change between events,
// but only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ghtm_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int WATCHDOG_LIMIT = 200000;

    class match_scoreboard;
        int trk_u[ghtm_pkg::MAX_TRACKS_DEF];
        int trk_v[ghtm_pkg::MAX_TRACKS_DEF];
        int hit_u[ghtm_pkg::MAX_HITS_DEF];
        int hit_v[ghtm_pkg::MAX_HITS_DEF];
        int n_trk;
        int n_hit;
        bit dropped;
        int cut_u;
        int cut_v;
        ghtm_pkg::out_item_t expected_results[$];
        int errors;

        function new();
            cut_u = int'(ghtm_pkg::CUT_RESET);
            cut_v = int'(ghtm_pkg::CUT_RESET);
            n_trk = 0;
            n_hit = 0;
            dropped = 1'b0;
            errors = 0;
        endfunction

        function void set_cut(logic [ghtm_pkg::CFG_IDX_W-1:0] idx,
                              logic [ghtm_pkg::CUT_W-1:0] val);
            if (idx == ghtm_pkg::CFG_MAX_RES_U) begin
                cut_u = int'(val);
            end else if (idx == ghtm_pkg::CFG_MAX_RES_V) begin
                cut_v = int'(val);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(ghtm_pkg::in_item_t req);
            case (req.operation)
                ghtm_pkg::OP_LOAD_TRACK: begin
                    if (n_trk < ghtm_pkg::MAX_TRACKS_DEF) begin
                        trk_u[n_trk] = int'($signed(req.coord_u));
                        trk_v[n_trk] = int'($signed(req.coord_v));
                        n_trk++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                ghtm_pkg::OP_LOAD_HIT: begin
                    if (n_hit < ghtm_pkg::MAX_HITS_DEF) begin
                        hit_u[n_hit] = int'($signed(req.coord_u));
                        hit_v[n_hit] = int'($signed(req.coord_v));
                        n_hit++;
                    end else begin
                        dropped = 1'b1;
                    end
                end
                ghtm_pkg::OP_END_EVENT: pair_event();
                default: ;
            endcase
        endfunction

        // Greedy pairing: repeatedly take the closest free pair, first in
        // track-major order on ties, then emit one result per hit (one if none).
        function void pair_event();
            bit trk_used[ghtm_pkg::MAX_TRACKS_DEF];
            bit hit_used[ghtm_pkg::MAX_HITS_DEF];
            int partner[ghtm_pkg::MAX_HITS_DEF];
            int pair_dist[ghtm_pkg::MAX_HITS_DEF];
            int n_pairs;
            int best_d;
            int best_t;
            int best_h;
            int du;
            int dv;
            int d;
            int n;
            bit found;
            ghtm_pkg::out_item_t r;
            n_pairs = 0;
            foreach (hit_used[h]) begin
                hit_used[h] = 1'b0;
                partner[h] = 0;
                pair_dist[h] = 0;
            end
            foreach (trk_used[t]) trk_used[t] = 1'b0;
            forever begin
                found = 1'b0;
                best_d = 0;
                best_t = 0;
                best_h = 0;
                for (int t = 0; t < n_trk; t++) begin
                    if (trk_used[t]) continue;
                    for (int h = 0; h < n_hit; h++) begin
                        if (hit_used[h]) continue;
                        du = trk_u[t] - hit_u[h];
                        dv = trk_v[t] - hit_v[h];
                        if (du < 0) du = -du;
                        if (dv < 0) dv = -dv;
                        if (cut_u != 0 && du >= cut_u) continue;
                        if (cut_v != 0 && dv >= cut_v) continue;
                        d = 0;
                        if (cut_u != 0) d += du;
                        if (cut_v != 0) d += dv;
                        if (!found || d < best_d) begin
                            found = 1'b1;
                            best_d = d;
                            best_t = t;
                            best_h = h;
                        end
                    end
                end
                if (!found) break;
                trk_used[best_t] = 1'b1;
                hit_used[best_h] = 1'b1;
                partner[best_h] = best_t;
                pair_dist[best_h] = best_d;
                n_pairs++;
            end

            n = (n_hit < ghtm_pkg::RESULT_LIMIT) ? n_hit : ghtm_pkg::RESULT_LIMIT;
            if (n == 0) begin
                r = '0;
                r.match_count = n_pairs[ghtm_pkg::OUT_CNT_W-1:0];
                r.overflow = dropped;
                r.last = 1'b1;
                expected_results.insert(expected_results.size(), r);
            end else begin
                for (int k = 0; k < n; k++) begin
                    r.hit_valid = 1'b1;
                    r.hit_index = k[ghtm_pkg::OUT_IDX_W-1:0];
                    r.has_track = hit_used[k];
                    r.track_index = hit_used[k] ? partner[k][ghtm_pkg::OUT_IDX_W-1:0] : '0;
                    r.match_distance = hit_used[k] ? pair_dist[k][ghtm_pkg::DIST_W-1:0]
                                                   : '0;
                    r.match_count = n_pairs[ghtm_pkg::OUT_CNT_W-1:0];
                    r.overflow = dropped;
                    r.last = (k == n - 1);
                    expected_results.insert(expected_results.size(), r);
                end
            end
            n_trk = 0;
            n_hit = 0;
            dropped = 1'b0;
        endfunction

        function string describe(ghtm_pkg::out_item_t r);
            return $sformatf("hv=%0d hit=%0d ht=%0d trk=%0d d=%0d cnt=%0d ovf=%0d last=%0d",
                             r.hit_valid, r.hit_index, r.has_track, r.track_index,
                             r.match_distance, r.match_count, r.overflow, r.last);
        endfunction

        function void check_result(ghtm_pkg::out_item_t got);
            ghtm_pkg::out_item_t want;
            if (expected_results.size() == 0) begin
                if (errors < 10) begin
                    $display("ERROR: unexpected result %s", describe(got));
                end
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.hit_valid !== want.hit_valid || got.hit_index !== want.hit_index ||
                got.has_track !== want.has_track || got.track_index !== want.track_index ||
                got.match_distance !== want.match_distance ||
                got.match_count !== want.match_count ||
                got.overflow !== want.overflow || got.last !== want.last) begin
                if (errors < 10) begin
                    $display("ERROR: result mismatch at %0t", $realtime);
                    $display("  expected %s", describe(want));
                    $display("  actual   %s", describe(got));
                end
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    ghtm_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ghtm_pkg::out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [ghtm_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [ghtm_pkg::CUT_W-1:0] cfg_wdata = '0;

    match_scoreboard sb = new();
    int send_idle_pct = 27;
    int recv_idle_pct = 67;
    int recv_hold_req = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    int items_sent = 0;

    greedy_hit_track_matcher DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // handshake monitor and idle counter for the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // result side: random back-pressure plus a long hold-off when one is requested
    always begin
        @(negedge aclk);
        if (recv_hold_req > 0) begin
            hold_left = recv_hold_req;
            recv_hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic int jitter(input int cut);
        int span;
        span = (cut == 0) ? 3000 : cut + cut / 4 + 1;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic send_request(input logic [ghtm_pkg::OP_W-1:0] op, input int u,
                                input int v);
        ghtm_pkg::in_item_t req;
        req.operation = op;
        req.coord_u = u[ghtm_pkg::COORD_W-1:0];
        req.coord_v = v[ghtm_pkg::COORD_W-1:0];
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
    endtask

    task automatic apply_cuts(input int cu, input int cv);
        drain_results();
        repeat (8) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= ghtm_pkg::CFG_MAX_RES_U;
        cfg_wdata <= cu[ghtm_pkg::CUT_W-1:0];
        @(negedge aclk);
        cfg_addr <= ghtm_pkg::CFG_MAX_RES_V;
        cfg_wdata <= cv[ghtm_pkg::CUT_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        sb.set_cut(ghtm_pkg::CFG_MAX_RES_U, cu[ghtm_pkg::CUT_W-1:0]);
        sb.set_cut(ghtm_pkg::CFG_MAX_RES_V, cv[ghtm_pkg::CUT_W-1:0]);
    endtask

    // One event: tracks, hits mostly placed near a track, mixed load order,
    // stray reserved-op requests, then end of event.
    task automatic run_event(input int n_trk, input int n_hit, input bit grid);
        int tu[$];
        int tv[$];
        int hu[$];
        int hv[$];
        int ti;
        int hi;
        int k;
        for (int i = 0; i < n_trk; i++) begin
            if (grid) begin
                tu.insert(tu.size(), int'($urandom_range(0, 3)) * 6);
                tv.insert(tv.size(), int'($urandom_range(0, 3)) * 6);
            end else if ($urandom_range(0, 3) == 0) begin
                tu.insert(tu.size(), int'($urandom()));
                tv.insert(tv.size(), int'($urandom()));
            end else begin
                tu.insert(tu.size(), int'($urandom_range(0, 40000)) - 20000);
                tv.insert(tv.size(), int'($urandom_range(0, 40000)) - 20000);
            end
        end
        for (int i = 0; i < n_hit; i++) begin
            if (grid) begin
                hu.insert(hu.size(), int'($urandom_range(0, 3)) * 6);
                hv.insert(hv.size(), int'($urandom_range(0, 3)) * 6);
            end else if (n_trk > 0 && $urandom_range(0, 99) < 75) begin
                k = $urandom_range(0, n_trk - 1);
                hu.insert(hu.size(), tu[k] + jitter(sb.cut_u));
                hv.insert(hv.size(), tv[k] + jitter(sb.cut_v));
            end else begin
                hu.insert(hu.size(), int'($urandom()));
                hv.insert(hv.size(), int'($urandom()));
            end
        end
        ti = 0;
        hi = 0;
        while (ti < n_trk || hi < n_hit) begin
            if ($urandom_range(0, 99) < 5) begin
                send_request(OP_RESERVED, int'($urandom()), int'($urandom()));
            end
            if (hi >= n_hit || (ti < n_trk && $urandom_range(0, 2) != 0)) begin
                send_request(ghtm_pkg::OP_LOAD_TRACK, tu[ti], tv[ti]);
                ti++;
            end else begin
                send_request(ghtm_pkg::OP_LOAD_HIT, hu[hi], hv[hi]);
                hi++;
            end
        end
        send_request(ghtm_pkg::OP_END_EVENT, int'($urandom()), int'($urandom()));
        items_sent += n_trk + n_hit + 1;
    endtask

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("status: fail");
        $finish;
    end

    initial begin
        int cu;
        int cv;
        int cut_set;
        int shape;
        int phase_start;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // event with no loads at all, coordinates on end of event ignored
        send_request(ghtm_pkg::OP_END_EVENT, -524288, 524287);
        // reserved op ignored; exact match at the coordinate extremes,
        // track tie on a hit, a v residual that meets the cut, a far hit
        send_request(OP_RESERVED, 524287, -524288);
        send_request(ghtm_pkg::OP_LOAD_TRACK, 0, 0);
        send_request(ghtm_pkg::OP_LOAD_TRACK, 0, 0);
        send_request(ghtm_pkg::OP_LOAD_TRACK, 524287, -524288);
        send_request(ghtm_pkg::OP_LOAD_HIT, 1999, 0);
        send_request(ghtm_pkg::OP_LOAD_HIT, 0, 2000);
        send_request(ghtm_pkg::OP_LOAD_HIT, 524287, -524288);
        send_request(ghtm_pkg::OP_LOAD_HIT, -524288, 524287);
        send_request(ghtm_pkg::OP_END_EVENT, 0, 0);
        // tracks only
        send_request(ghtm_pkg::OP_LOAD_TRACK, 5, 5);
        send_request(ghtm_pkg::OP_END_EVENT, -1, -1);
        // hits only
        send_request(ghtm_pkg::OP_LOAD_HIT, 7, 7);
        send_request(ghtm_pkg::OP_LOAD_HIT, -1, -1);
        send_request(ghtm_pkg::OP_END_EVENT, 0, 0);
        // greedy order: closest pair goes first
        send_request(ghtm_pkg::OP_LOAD_TRACK, 0, 0);
        send_request(ghtm_pkg::OP_LOAD_TRACK, 10, 0);
        send_request(ghtm_pkg::OP_LOAD_HIT, 4, 0);
        send_request(ghtm_pkg::OP_LOAD_HIT, 11, 0);
        send_request(ghtm_pkg::OP_END_EVENT, 0, 0);
        // hit tie: first hit wins
        send_request(ghtm_pkg::OP_LOAD_TRACK, 100, -100);
        send_request(ghtm_pkg::OP_LOAD_HIT, 105, -100);
        send_request(ghtm_pkg::OP_LOAD_HIT, 95, -100);
        send_request(ghtm_pkg::OP_END_EVENT, 0, 0);

        cut_set = 0;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 67;
                recv_idle_pct = 27;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // full stores plus one dropped track and hit
                apply_cuts(5000, 5000);
                run_event(ghtm_pkg::MAX_TRACKS_DEF + 1, ghtm_pkg::MAX_HITS_DEF + 1, 1'b0);
                // sender waits for every result, then the receiver holds off
                // while two more events are offered
                drain_results();
                recv_hold_req = 400;
                run_event(3, 6, 1'b0);
                run_event(4, 5, 1'b0);
            end
            phase_start = items_sent;
            while (items_sent - phase_start < 20) begin
                case (cut_set % 8)
                    0: begin cu = 2000; cv = 2000; end
                    1: begin cu = 0; cv = 2500; end
                    2: begin cu = 3000; cv = 0; end
                    3: begin cu = 524287; cv = 524287; end
                    4: begin cu = 1; cv = 1; end
                    5: begin cu = 0; cv = 0; end
                    6: begin cu = 524287; cv = 0; end
                    default: begin
                        cu = $urandom_range(1, 8000);
                        cv = $urandom_range(1, 8000);
                    end
                endcase
                apply_cuts(cu, cv);
                cut_set++;
                shape = $urandom_range(0, 99);
                if (shape < 8) begin
                    run_event(0, $urandom_range(0, 3), 1'b0);
                end else if (shape < 16) begin
                    run_event($urandom_range(1, 4), 0, 1'b0);
                end else if (shape < 30) begin
                    run_event($urandom_range(1, 5), $urandom_range(1, 5), 1'b1);
                end else begin
                    run_event($urandom_range(1, 6), $urandom_range(1, 6), 1'b0);
                end
            end
        end

        drain_results();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
